// ===== design/ipta_pkg.sv =====
// Package: shared widths, codes and command/status structs for the frame table allocator.
package ipta_pkg;

    localparam int NUM_FRAMES  = 64;
    localparam int FRAME_W     = $clog2(NUM_FRAMES);
    localparam int CNT_W       = $clog2(NUM_FRAMES + 1);

    localparam int MODE_W      = 2;
    localparam int PID_W       = 16;
    localparam int PAGE_W      = 6;
    localparam int OFFSET_W    = 16;
    localparam int LENGTH_W    = 17;
    localparam int COUNT_W     = 7;
    localparam int PAGE_SIZE_W = 17;
    localparam int STATUS_W    = 2;
    localparam int FRAME_OUT_W = 6;
    localparam int FIRST_W     = 7;

    localparam int ENTRY_W     = PID_W + PAGE_W;
    localparam int CMP_W       = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SUM_W       = LENGTH_W + 1;

    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET = PAGE_SIZE_W'(256);

    localparam logic [MODE_W-1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE      = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BEYOND_END = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FRAMES  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [PID_W-1:0]    process_id;
        logic [PAGE_W-1:0]   page_number;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic [COUNT_W-1:0]  page_count;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [FRAME_OUT_W-1:0] frame;
        logic [FIRST_W-1:0]     first_new_page;
    } result_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic assign_start;
        logic assign_en;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic assign_done;
        logic alloc_go;
    } stat_t;

endpackage

// ===== design/ipta_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
interface ipta_req_if;
    import ipta_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [PID_W-1:0]    process_id;
    logic [PAGE_W-1:0]   page_number;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [COUNT_W-1:0]  page_count;

    modport source (
        output valid, mode, process_id, page_number, offset, length, page_count,
        input  ready
    );
    modport sink (
        input  valid, mode, process_id, page_number, offset, length, page_count,
        output ready
    );
endinterface

interface ipta_rsp_if;
    import ipta_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [FRAME_OUT_W-1:0] frame;
    logic [FIRST_W-1:0]     first_new_page;

    modport source (
        output valid, status, frame, first_new_page,
        input  ready
    );
    modport sink (
        input  valid, status, frame, first_new_page,
        output ready
    );
endinterface

// ===== design/inverted_page_table_allocator_unit.sv =====
// Top level: inverted page table frame allocator (translate, allocate, free).
//
//   channel   | dir | payload                                              | handshake
//   request   | in  | mode process_id page_number offset length page_count | valid/ready
//   response  | out | status frame first_new_page                          | valid/ready
//   cfg       | in  | page_size (cfg_wr_data)                              | cfg_wr_en
//
// Each request beat runs one pass over the 64-entry table, one entry per cycle through
// the registered table read. An allocate that grants frames adds a second pass for
// assignment. Reset clears every in-use flag at once; page_size returns to 256. A
// stalled response beat holds in its register; the next request beat is taken while it
// waits.
module inverted_page_table_allocator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    ipta_req_if.sink                         request,
    ipta_rsp_if.source                       response,
    input  logic                             cfg_wr_en,
    input  logic [ipta_pkg::PAGE_SIZE_W-1:0] cfg_wr_data
);
    import ipta_pkg::*;

    cmd_t    cmd;
    stat_t   stat;
    item_t   item;
    result_t result;

    assign item.mode        = request.mode;
    assign item.process_id  = request.process_id;
    assign item.page_number = request.page_number;
    assign item.offset      = request.offset;
    assign item.length      = request.length;
    assign item.page_count  = request.page_count;

    assign response.status         = result.status;
    assign response.frame          = result.frame;
    assign response.first_new_page = result.first_new_page;

    ipta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .out_ready (response.ready),
        .stat      (stat),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .cmd       (cmd)
    );

    ipta_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item        (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .result      (result)
    );

`ifndef SYNTHESIS
    a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!response.valid || response.ready))
        else $error("result loaded over a pending beat");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request taken while an item is in flight");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && (response.status != ST_OK))
            |-> (response.frame == '0 && response.first_new_page == '0))
        else $error("error response carries nonzero frame or page");

    a_assign_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.assign_start |-> (stat.scan_done && stat.alloc_go))
        else $error("assignment pass started without a valid allocate");
`endif

endmodule

// ===== design/ipta_datapath.sv =====
// Datapath: frame table storage, scan counter, tallies and result register.
module ipta_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ipta_pkg::cmd_t                    cmd,
    input  ipta_pkg::item_t                   item,
    input  logic                              cfg_wr_en,
    input  logic [ipta_pkg::PAGE_SIZE_W-1:0]  cfg_wr_data,
    output ipta_pkg::stat_t                   stat,
    output ipta_pkg::result_t                 result
);
    import ipta_pkg::*;

    logic [NUM_FRAMES-1:0]  in_use_reg;
    logic [ENTRY_W-1:0]     table_mem [NUM_FRAMES];
    logic [ENTRY_W-1:0]     rd_data_reg;
    item_t                  item_reg;
    logic [PAGE_SIZE_W-1:0] page_size_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       owned_reg;
    logic [CNT_W-1:0]       free_reg;
    logic [COUNT_W-1:0]     given_reg;
    logic                   eval_valid_reg;
    logic                   eval_used_reg;
    logic [FRAME_W-1:0]     eval_idx_reg;
    logic                   found_reg;
    logic [FRAME_W-1:0]     hit_reg;
    result_t                res_reg;
    result_t                res_next;

    logic [FRAME_W-1:0] addr;
    logic               scan_end;
    logic               scan_issue;
    logic               assign_active;
    logic               grant;
    logic               eval_owned;
    logic               alloc_ok;
    logic [PID_W-1:0]   eval_owner;
    logic [PAGE_W-1:0]  eval_page;
    logic [PAGE_W-1:0]  new_page;
    logic [SUM_W-1:0]   access_end;

    assign addr          = cnt_reg[FRAME_W-1:0];
    assign scan_end      = (cnt_reg == CNT_W'(NUM_FRAMES));
    assign scan_issue    = cmd.scan_en && !scan_end;
    assign assign_active = cmd.assign_en && !scan_end && (given_reg != item_reg.page_count);
    assign grant         = assign_active && !in_use_reg[addr];
    assign eval_owner    = rd_data_reg[ENTRY_W-1 -: PID_W];
    assign eval_page     = rd_data_reg[PAGE_W-1:0];
    assign eval_owned    = eval_valid_reg && eval_used_reg && (eval_owner == item_reg.process_id);
    assign alloc_ok      = CMP_W'(free_reg) >= CMP_W'(item_reg.page_count);
    assign new_page      = PAGE_W'(CMP_W'(owned_reg) + CMP_W'(given_reg));
    assign access_end    = SUM_W'(item_reg.offset) + SUM_W'(item_reg.length);

    assign stat.scan_done   = scan_end && !eval_valid_reg;
    assign stat.assign_done = scan_end || (given_reg == item_reg.page_count);
    assign stat.alloc_go    = (item_reg.mode == MODE_ALLOC) && alloc_ok
                              && (item_reg.page_count != '0);

    always_comb
    begin
        res_next = '0;
        unique case (item_reg.mode)
            MODE_TRANSLATE:
            begin
                if (!found_reg)
                begin
                    res_next.status = ST_NOT_MAPPED;
                end
                else if (access_end > SUM_W'(page_size_reg))
                begin
                    res_next.status = ST_BEYOND_END;
                end
                else
                begin
                    res_next.frame = FRAME_OUT_W'(hit_reg);
                end
            end
            MODE_ALLOC:
            begin
                if (alloc_ok)
                begin
                    res_next.first_new_page = FIRST_W'(owned_reg);
                end
                else
                begin
                    res_next.status = ST_NO_FRAMES;
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg     <= '0;
            page_size_reg  <= PAGE_SIZE_RESET;
            cnt_reg        <= '0;
            eval_valid_reg <= 1'b0;
            owned_reg      <= '0;
            free_reg       <= '0;
            given_reg      <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                page_size_reg <= cfg_wr_data;
            end

            if (cmd.load || cmd.assign_start)
            begin
                cnt_reg <= '0;
            end
            else if (scan_issue || assign_active)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            eval_valid_reg <= scan_issue;

            if (cmd.load)
            begin
                owned_reg <= '0;
                free_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (eval_valid_reg)
            begin
                if (eval_owned)
                begin
                    owned_reg <= owned_reg + 1'b1;
                end
                if (!eval_used_reg)
                begin
                    free_reg <= free_reg + 1'b1;
                end
                if (eval_owned && (eval_page == item_reg.page_number) && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.assign_start)
            begin
                given_reg <= '0;
            end
            else if (grant)
            begin
                given_reg <= given_reg + 1'b1;
            end

            if (eval_owned && (item_reg.mode == MODE_FREE))
            begin
                in_use_reg[eval_idx_reg] <= 1'b0;
            end
            if (grant)
            begin
                in_use_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grant)
        begin
            table_mem[addr] <= {item_reg.process_id, new_page};
        end
        rd_data_reg   <= table_mem[addr];
        eval_used_reg <= in_use_reg[addr];
        eval_idx_reg  <= addr;
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (eval_owned && (eval_page == item_reg.page_number) && !found_reg)
        begin
            hit_reg <= eval_idx_reg;
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// ===== design/ipta_ctrl.sv =====
// Controller: sequences table scan, frame assignment and result hand-off.
module ipta_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_ready,
    input  ipta_pkg::stat_t stat,
    output logic            in_ready,
    output logic            out_valid,
    output ipta_pkg::cmd_t  cmd
);
    import ipta_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ASSIGN,
        S_REPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        cmd              = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.alloc_go)
                    begin
                        cmd.assign_start = 1'b1;
                        state_next       = S_ASSIGN;
                    end
                    else
                    begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_ASSIGN:
            begin
                cmd.assign_en = 1'b1;
                if (stat.assign_done)
                begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (slot_free)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
